// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// Field widths.
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;

	// Item kinds.
	localparam logic [1:0] KIND_STREAM = 2'd0;
	localparam logic [1:0] KIND_PLACE  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// Character codes with a special meaning.
	localparam logic [CHAR_W-1:0] CH_DEL       = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cursor_t;

	// Decoded action of a stream character at the current cursor.
	typedef struct packed {
		logic print;
		logic scroll;
	} cur_ctl_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		cell_t data;
	} mem_wr_t;

	function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		int unsigned lin;
		lin = int'(row) * COLUMNS + int'(col);
		return lin[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/tcw_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [CHAR_W-1:0] char_code,
	output cursor_t                cur,
	output cur_ctl_t               ctl
);

	cursor_t cur_q;
	cursor_t cur_next;
	logic    last_row;
	logic    last_col;

	assign last_row = (cur_q.row == ROW_W'(ROWS - 1));
	assign last_col = (cur_q.col == COL_W'(COLUMNS - 1));

	always_comb begin
		cur_next   = cur_q;
		ctl.print  = 1'b0;
		ctl.scroll = 1'b0;
		if (char_code == CH_NEWLINE) begin
			cur_next.col = '0;
			if (last_row) begin
				ctl.scroll = 1'b1;
			end else begin
				cur_next.row = cur_q.row + 1'b1;
			end
		end else if (char_code == CH_BACKSPACE || char_code == CH_DEL) begin
			if (cur_q.col != '0) begin
				cur_next.col = cur_q.col - 1'b1;
			end
		end else if (char_code == CH_RETURN) begin
			cur_next.col = '0;
		end else if (char_code != CH_BELL) begin
			ctl.print = 1'b1;
			if (last_col) begin
				cur_next.col = '0;
				if (last_row) begin
					ctl.scroll = 1'b1;
				end else begin
					cur_next.row = cur_q.row + 1'b1;
				end
			end else begin
				cur_next.col = cur_q.col + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= cur_next;
		end
	end

	assign cur = cur_q;

endmodule

`default_nettype wire

// File: hdl/tcw_sweep.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_sweep
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              scroll_start,
	input  wire logic [ATTR_W-1:0] text_attribute,
	input  wire cell_t             rd_data,
	output addr_t                  rd_addr,
	output mem_wr_t                wr,
	output logic                   busy
);

	typedef enum logic [1:0] {
		SW_IDLE = 2'b01,
		SW_RUN  = 2'b10
	} sweep_state_t;

	sweep_state_t state_q;
	addr_t        ptr_q;
	logic         clear_q;
	cell_t        blank_q;
	logic         wr_en_s1;
	addr_t        wr_addr_s1;
	logic         fill_s1;

	// A moved cell comes from one row further down, read in the cycle before.
	assign rd_addr = ptr_q + addr_t'(COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SW_RUN;
			ptr_q    <= '0;
			clear_q  <= 1'b1;
			blank_q  <= CELL_RESET;
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= 1'b0;
			unique case (state_q)
				SW_IDLE: begin
					if (scroll_start) begin
						state_q <= SW_RUN;
						ptr_q   <= '0;
						clear_q <= 1'b0;
						blank_q <= {text_attribute, CH_SPACE};
					end
				end
				SW_RUN: begin
					wr_en_s1 <= 1'b1;
					if (ptr_q == addr_t'(CELL_COUNT - 1)) begin
						state_q <= SW_IDLE;
						ptr_q   <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= SW_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q;
		fill_s1    <= clear_q || (ptr_q >= addr_t'(CELL_COUNT - COLUMNS));
	end

	assign wr.en   = wr_en_s1;
	assign wr.addr = wr_addr_s1;
	assign wr.data = fill_s1 ? blank_q : rd_data;
	assign busy    = (state_q == SW_RUN) || wr_en_s1;

endmodule

`default_nettype wire

// File: hdl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// The result word appears in the cycle after its item is taken, for exactly one cycle.
// One item per cycle while busy is low; the receiver cannot stall and needs no buffering.
// A character that scrolls keeps busy high while the copy reads one row ahead, moves
// every row up one cell per cycle and blanks the bottom row.
// Reset: asynchronous, active low; a clearing pass then fills the screen with grey
// spaces, with busy high throughout. Cursor resets to the top-left corner.

module text_console_writer
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        kind,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [COL_W-1:0]  pos_column,
	input  wire logic [ROW_W-1:0]  pos_row,
	input  wire logic [ATTR_W-1:0] cell_attribute,
	input  wire logic              text_attribute_we,
	input  wire logic [ATTR_W-1:0] text_attribute_wdata,
	output logic                   done,
	output logic [COL_W-1:0]       cursor_column,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [CELL_W-1:0]      cell_value
);

	logic [ATTR_W-1:0] text_attribute_q;
	logic              accept;
	logic              stream_step;
	logic              on_screen;
	addr_t             pos_addr;
	cursor_t           cur;
	cur_ctl_t          ctl;
	mem_wr_t           item_wr;
	mem_wr_t           sweep_wr;
	mem_wr_t           ram_wr;
	addr_t             sweep_rd_addr;
	addr_t             ram_rd_addr;
	cell_t             rd_data;
	logic              sweep_busy;
	logic              done_q;
	logic              read_q;

	// The current colour byte: the user must write it only while the block is idle; unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= ATTR_RESET;
		end else if (text_attribute_we) begin
			text_attribute_q <= text_attribute_wdata;
		end
	end

	assign busy        = sweep_busy;
	assign accept      = start && !busy;
	assign stream_step = accept && (kind == KIND_STREAM);
	assign on_screen   = (pos_column < COL_W'(COLUMNS)) && (pos_row < ROW_W'(ROWS));
	assign pos_addr    = cell_addr(pos_row, pos_column);

	// Cursor registers and the decoding of stream characters.
	tcw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (stream_step),
		.char_code (char_code),
		.cur       (cur),
		.ctl       (ctl)
	);

	// The sweep engine serves both the clearing pass after reset and the scroll copy.
	tcw_sweep u_sweep (
		.clk            (clk),
		.arst_n         (arst_n),
		.scroll_start   (stream_step && ctl.scroll),
		.text_attribute (text_attribute_q),
		.rd_data        (rd_data),
		.rd_addr        (sweep_rd_addr),
		.wr             (sweep_wr),
		.busy           (sweep_busy)
	);

	// An item writes at most one cell itself: a printed character at the cursor before it
	// moves, or a placed cell at a position that lies on the screen.
	always_comb begin
		item_wr.en   = 1'b0;
		item_wr.addr = pos_addr;
		item_wr.data = {cell_attribute, char_code};
		if (stream_step && ctl.print) begin
			item_wr.en   = 1'b1;
			item_wr.addr = cell_addr(cur.row, cur.col);
			item_wr.data = {text_attribute_q, char_code};
		end else if (accept && (kind == KIND_PLACE) && on_screen) begin
			item_wr.en = 1'b1;
		end
	end

	// No item is taken while the sweep runs, so the two writers never meet.
	assign ram_wr      = sweep_wr.en ? sweep_wr : item_wr;
	assign ram_rd_addr = busy ? sweep_rd_addr : pos_addr;

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_rd_addr),
		.rdata (rd_data)
	);

	// The result word appears in the cycle after its item; a read cell arrives from the
	// memory's output register in that same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			read_q <= 1'b0;
		end else begin
			done_q <= accept;
			read_q <= accept && (kind == KIND_READ) && on_screen;
		end
	end

	assign done          = done_q;
	assign cursor_column = cur.col;
	assign cursor_row    = cur.row;
	assign cell_value    = read_q ? rd_data : '0;

endmodule

`default_nettype wire

// File: dv/text_console_writer_checker.sv
`timescale 1ns / 1ps

// Watches the console's command and result channels, predicts each result word and
// compares it with what the block returns.
module text_console_writer_checker
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [1:0]        kind,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [COL_W-1:0]  pos_column,
	input  wire logic [ROW_W-1:0]  pos_row,
	input  wire logic [ATTR_W-1:0] cell_attribute,
	input  wire logic              text_attribute_we,
	input  wire logic [ATTR_W-1:0] text_attribute_wdata,
	input  wire logic              done,
	input  wire logic [COL_W-1:0]  cursor_column,
	input  wire logic [ROW_W-1:0]  cursor_row,
	input  wire logic [CELL_W-1:0] cell_value,
	output int                     mismatches,
	output int                     pending
);

	typedef struct {
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
		logic [CELL_W-1:0] cell_value;
	} console_word_t;

	cell_t             screen_image [CELL_COUNT];
	int unsigned       cur_col;
	int unsigned       cur_row;
	logic [ATTR_W-1:0] text_attr;
	console_word_t     expected_words [$];
	int                mismatch_count = 0;

	assign mismatches = mismatch_count;
	assign pending    = expected_words.size();

	function automatic void clear_console();
		for (int i = 0; i < CELL_COUNT; i++)
			screen_image[i] = CELL_RESET;
		cur_col   = 0;
		cur_row   = 0;
		text_attr = ATTR_RESET;
	endfunction

	function automatic void scroll_screen();
		for (int i = COLUMNS; i < CELL_COUNT; i++)
			screen_image[i - COLUMNS] = screen_image[i];
		for (int i = 0; i < COLUMNS; i++)
			screen_image[(ROWS - 1) * COLUMNS + i] = {text_attr, CH_SPACE};
		cur_row = ROWS - 1;
		cur_col = 0;
	endfunction

	function automatic void advance_row();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS)
			scroll_screen();
	endfunction

	function automatic void print_char(input logic [CHAR_W-1:0] ch);
		if (ch == CH_NEWLINE) begin
			advance_row();
		end else if (ch == CH_BACKSPACE || ch == CH_DEL) begin
			if (cur_col > 0)
				cur_col--;
		end else if (ch == CH_RETURN) begin
			cur_col = 0;
		end else if (ch != CH_BELL) begin
			screen_image[cur_row * COLUMNS + cur_col] = {text_attr, ch};
			cur_col++;
			if (cur_col >= COLUMNS)
				advance_row();
		end
	endfunction

	function automatic console_word_t console_step(input logic [1:0] k,
			input logic [CHAR_W-1:0] ch, input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row, input logic [ATTR_W-1:0] attr);
		console_word_t w;
		logic          on_screen;
		int unsigned   idx;
		on_screen    = (int'(col) < COLUMNS) && (int'(row) < ROWS);
		idx          = int'(row) * COLUMNS + int'(col);
		w.cell_value = '0;
		case (k)
			KIND_STREAM: begin
				print_char(ch);
			end
			KIND_PLACE: begin
				if (on_screen)
					screen_image[idx] = {attr, ch};
			end
			KIND_READ: begin
				if (on_screen)
					w.cell_value = screen_image[idx];
			end
			default: begin
			end
		endcase
		w.cursor_column = cur_col[COL_W-1:0];
		w.cursor_row    = cur_row[ROW_W-1:0];
		return w;
	endfunction

	// The result of an item comes in the cycle after it, so the oldest expectation is
	// checked before the item taken at the same edge is added. A register write at
	// that edge only affects the items that follow it.
	always @(posedge clk or negedge arst_n) begin
		console_word_t want;
		if (!arst_n) begin
			clear_console();
			expected_words.delete();
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with no item waiting for it");
					mismatch_count++;
				end else begin
					want = expected_words.pop_front();
					if (cursor_column !== want.cursor_column) begin
						$error("cursor_column: expected %0d, got %0d",
							want.cursor_column, cursor_column);
						mismatch_count++;
					end
					if (cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, got %0d",
							want.cursor_row, cursor_row);
						mismatch_count++;
					end
					if (cell_value !== want.cell_value) begin
						$error("cell_value: expected %h, got %h",
							want.cell_value, cell_value);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				expected_words.push_back(console_step(kind, char_code, pos_column,
					pos_row, cell_attribute));
			if (text_attribute_we)
				text_attr = text_attribute_wdata;
		end
	end

endmodule

// File: dv/text_console_writer_test.sv
`timescale 1ns / 1ps

// Top of the console testbench. It generates the clock and reset, drives command
// words into the console and rewrites the text attribute between phases. All
// prediction and comparison is done by the checker beside the block; this module
// only decides the verdict, from the checker's mismatch count and a stall watchdog.
module text_console_writer_test;
	import tcw_pkg::*;

	// Kind code that the block does not use; it must leave everything unchanged.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// A scroll or the clearing pass after reset keeps busy high for a sweep of every
	// cell, so a quiet stretch has to be well beyond that before we give up.
	localparam int STALL_LIMIT = 20000;

	// Roughly this many random words follow the directed ones; after the gap
	// cut-off the sender runs flat out.
	localparam int RANDOM_WORDS = 1400;
	localparam int GAP_CUTOFF   = 1200;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        kind;
	logic [CHAR_W-1:0] char_code;
	logic [COL_W-1:0]  pos_column;
	logic [ROW_W-1:0]  pos_row;
	logic [ATTR_W-1:0] cell_attribute;
	logic              text_attribute_we;
	logic [ATTR_W-1:0] text_attribute_wdata;
	logic              done;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic [CELL_W-1:0] cell_value;
	int                mismatches;
	int                pending;

	bit gaps_on;
	int words_sent;

	text_console_writer dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.kind                 (kind),
		.char_code            (char_code),
		.pos_column           (pos_column),
		.pos_row              (pos_row),
		.cell_attribute       (cell_attribute),
		.text_attribute_we    (text_attribute_we),
		.text_attribute_wdata (text_attribute_wdata),
		.done                 (done),
		.cursor_column        (cursor_column),
		.cursor_row           (cursor_row),
		.cell_value           (cell_value)
	);

	text_console_writer_checker scoreboard (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.kind                 (kind),
		.char_code            (char_code),
		.pos_column           (pos_column),
		.pos_row              (pos_row),
		.cell_attribute       (cell_attribute),
		.text_attribute_we    (text_attribute_we),
		.text_attribute_wdata (text_attribute_wdata),
		.done                 (done),
		.cursor_column        (cursor_column),
		.cursor_row           (cursor_row),
		.cell_value           (cell_value),
		.mismatches           (mismatches),
		.pending              (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Presents one command word from a falling edge and holds it until a rising
	// edge finds busy low. It returns on the falling edge after the handshake
	// with start still high, so that a following word goes out back to back
	// without start dropping in between.
	task automatic send_word(input logic [1:0] k, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [ATTR_W-1:0] attr);
		bit taken;
		kind           = k;
		char_code      = ch;
		pos_column     = col;
		pos_row        = row;
		cell_attribute = attr;
		start          = 1'b1;
		taken          = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// Sends a word, sometimes after a burst of idle cycles. Whether gaps are
	// allowed at all is decided afresh every few dozen words, which gives long
	// stretches of back-to-back traffic as well as gaps on every phase of the
	// block's work, scrolls included.
	task automatic issue_word(input logic [1:0] k, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [ATTR_W-1:0] attr);
		if (words_sent % 40 == 0)
			gaps_on = (words_sent < GAP_CUTOFF) && ($urandom_range(0, 2) != 0);
		if (gaps_on && $urandom_range(0, 99) < 25) begin
			start = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		send_word(k, ch, col, row, attr);
		words_sent++;
	endtask

	// The attribute may only change while the console is idle: every result has
	// come back and any scroll copy has finished.
	task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		text_attribute_we    = 1'b1;
		text_attribute_wdata = value;
		@(negedge clk);
		text_attribute_we    = 1'b0;
	endtask

	// A byte that lands on screen as an ordinary character: anything but the
	// five codes that move the cursor or are ignored.
	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] ch;
		ch = CH_NEWLINE;
		while (ch == CH_NEWLINE || ch == CH_RETURN || ch == CH_BACKSPACE ||
				ch == CH_DEL || ch == CH_BELL) begin
			if ($urandom_range(0, 3) == 0)
				ch = CHAR_W'($urandom_range(0, 255));
			else
				ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
		end
		return ch;
	endfunction

	// Any stream byte, with the control codes weighted well above their share.
	function automatic logic [CHAR_W-1:0] stream_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return CH_NEWLINE;
		else if (pick < 11)
			return CH_RETURN;
		else if (pick < 17)
			return CH_BACKSPACE;
		else if (pick < 20)
			return CH_DEL;
		else if (pick < 24)
			return CH_BELL;
		else
			return plain_char();
	endfunction

	// One word of random traffic: about half stream characters, places and reads
	// that usually fall on the screen and now and then outside it.
	task automatic random_word();
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		int               pick;
		col = COL_W'($urandom_range(0, COLUMNS - 1));
		row = ROW_W'($urandom_range(0, ROWS - 1));
		if ($urandom_range(0, 99) < 12) begin
			if ($urandom_range(0, 1) != 0)
				col = COL_W'($urandom_range(COLUMNS, 127));
			else
				row = ROW_W'($urandom_range(ROWS, 31));
		end
		pick = $urandom_range(0, 99);
		if (pick < 50)
			issue_word(KIND_STREAM, stream_char(), COL_W'($urandom_range(0, 127)),
				ROW_W'($urandom_range(0, 31)), ATTR_W'($urandom_range(0, 255)));
		else if (pick < 72)
			issue_word(KIND_PLACE, CHAR_W'($urandom_range(0, 255)), col, row,
				ATTR_W'($urandom_range(0, 255)));
		else if (pick < 96)
			issue_word(KIND_READ, CHAR_W'($urandom_range(0, 255)), col, row,
				ATTR_W'($urandom_range(0, 255)));
		else
			issue_word(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)),
				COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)),
				ATTR_W'($urandom_range(0, 255)));
	endtask

	// A line of text as a terminal would see it: a run of plain characters, long
	// enough at times to wrap, usually ended by a carriage return and newline.
	task automatic text_line();
		int length;
		length = $urandom_range(1, 100);
		repeat (length)
			issue_word(KIND_STREAM, plain_char(), COL_W'($urandom_range(0, 127)),
				ROW_W'($urandom_range(0, 31)), ATTR_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) < 7) begin
			issue_word(KIND_STREAM, CH_RETURN, 0, 0, 0);
			issue_word(KIND_STREAM, CH_NEWLINE, 0, 0, 0);
		end
	endtask

	initial begin
		logic [ATTR_W-1:0] phase_attr [6];
		int                phase_end;
		arst_n               = 1'b0;
		start                = 1'b0;
		kind                 = KIND_STREAM;
		char_code            = '0;
		pos_column           = '0;
		pos_row              = '0;
		cell_attribute       = '0;
		text_attribute_we    = 1'b0;
		text_attribute_wdata = '0;
		gaps_on              = 1'b0;
		words_sent           = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed words, run with the reset attribute. The first ones wait out
		// the clearing pass and then read back the corners of a fresh screen.
		send_word(KIND_READ, 8'h00, 0, 0, 8'h00);
		send_word(KIND_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1), 8'h00);
		// Reads and places outside the screen do nothing and read back zero.
		send_word(KIND_READ, 8'hFF, 127, 31, 8'hFF);
		send_word(KIND_PLACE, 8'h41, COL_W'(COLUMNS), 0, 8'h12);
		send_word(KIND_PLACE, 8'h42, 0, ROW_W'(ROWS), 8'h34);
		send_word(KIND_READ, 8'h00, COL_W'(COLUMNS), 0, 8'h00);
		send_word(KIND_READ, 8'h00, 0, ROW_W'(ROWS), 8'h00);
		// Extreme cells at the extreme positions.
		send_word(KIND_PLACE, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1), 8'hFF);
		send_word(KIND_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1), 8'h00);
		send_word(KIND_PLACE, 8'h00, 0, 0, 8'h00);
		send_word(KIND_READ, 8'hFF, 0, 0, 8'hFF);
		// The unused kind changes nothing and returns no cell.
		send_word(KIND_UNUSED, 8'hFF, 127, 31, 8'hFF);
		// Backspace and delete at column 0 must hold the cursor there.
		send_word(KIND_STREAM, CH_BACKSPACE, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_DEL, 0, 0, 8'h00);
		// High bytes and stray control bytes print as ordinary characters.
		send_word(KIND_STREAM, 8'h80, 0, 0, 8'h00);
		send_word(KIND_STREAM, 8'hFF, 0, 0, 8'h00);
		send_word(KIND_STREAM, 8'h00, 0, 0, 8'h00);
		send_word(KIND_STREAM, 8'h1B, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_BELL, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_DEL, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_BACKSPACE, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_RETURN, 0, 0, 8'h00);
		send_word(KIND_STREAM, CH_NEWLINE, 0, 0, 8'h00);
		send_word(KIND_READ, 8'h00, 1, 0, 8'h00);
		send_word(KIND_READ, 8'h00, 3, 0, 8'h00);

		// Random traffic in phases, each under its own attribute, both extremes
		// among them. The first phase keeps the reset attribute.
		phase_attr[0] = ATTR_RESET;
		phase_attr[1] = 8'h00;
		phase_attr[2] = 8'hFF;
		phase_attr[3] = ATTR_W'($urandom_range(0, 255));
		phase_attr[4] = 8'h1E;
		phase_attr[5] = ATTR_W'($urandom_range(0, 255));
		words_sent = 0;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase != 0)
				set_text_attribute(phase_attr[phase]);
			phase_end = (phase + 1) * RANDOM_WORDS / 6;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 99) < 30)
					text_line();
				else
					random_word();
			end
		end
		start = 1'b0;

		// Drain: every expected result word has to come back, then a short tail
		// catches any stray word.
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: any handshake, result word or register write counts as progress.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || text_attribute_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cursor.sv
hdl/tcw_sweep.sv
hdl/text_console_writer.sv
dv/text_console_writer_checker.sv
dv/text_console_writer_test.sv
